FILE: design/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

  localparam int COORD_BITS = 12;
  localparam int LEVEL_W    = 8;
  localparam int NUM_BARS   = 8;
  localparam int BAR_IDX_W  = 3;

  // Positions: bar borders plus half a ramp reach past 13 bits
  localparam int POS_W  = 14;
  localparam int BW_W   = 10;
  localparam int T_W    = 11;
  localparam int N_W    = 10;
  localparam int STEP_W = 16;
  localparam int PROD_W = 27;
  localparam int ROM_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_MAX_LEVEL       = 3'd2,
    CFG_EDGE_WIDTH      = 3'd3,
    CFG_EDGE_PHASE_STEP = 3'd4
  } cbp_cfg_e;

  localparam logic [12:0]       RST_FRAME_WIDTH     = 13'd640;
  localparam logic [12:0]       RST_FRAME_HEIGHT    = 13'd480;
  localparam logic [7:0]        RST_MAX_LEVEL       = 8'd191;
  localparam logic [9:0]        RST_EDGE_WIDTH      = 10'd0;
  localparam logic [STEP_W-1:0] RST_EDGE_PHASE_STEP = 16'hFFFF;

  // floor(v/5) == (v*DIV5_RECIP) >> DIV5_SHIFT for every v below 2^18
  localparam logic [16:0] DIV5_RECIP = 17'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Taylor divisors (2i)*(2i+1) of the sine series
  localparam logic [63:0] TAYLOR_DIV [1:11] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506
  };

  // Channel masks: bit 0 red, bit 1 green, bit 2 blue
  localparam logic [2:0] UPPER_MASK [NUM_BARS] = '{
    3'd7, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0
  };
  localparam logic [2:0] LOWER_MASK [NUM_BARS] = '{
    3'd0, 3'd0, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
  } cbp_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } cbp_out_t;

  function automatic logic [2:0] bar_mask(input logic [BAR_IDX_W-1:0] bar, input logic lower);
    bar_mask = lower ? LOWER_MASK[bar] : UPPER_MASK[bar];
  endfunction

endpackage

`default_nettype wire

FILE: design/color_bar_pattern_generator_unit.sv
`default_nettype none
// Each accepted input beat is registered in all nine pipeline stages on its way out.
// Throughput: one pixel per cycle unless the output stalls or a register write holds
// off pixels; two cosine ROM read ports serve the even and odd bar at each pixel.
// Stages advance independently, so empty stages fill while the output is stalled.
// Reset clears all valid bits and loads the registers with their default values.
module color_bar_pattern_generator_unit
  import cbp_pkg::*;
#(
  parameter int COSINE_ROM_DEPTH = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire cbp_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output cbp_out_t                   out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int          RomAw     = $clog2(COSINE_ROM_DEPTH);
  localparam int          KW        = PROD_W + RomAw + 1;
  localparam logic [63:0] RomDen    = 64'(2 * COSINE_ROM_DEPTH);
  localparam int          NumStages = 9;

  // ---------------------------------------------------------------- cosine ROM
  function automatic logic [ROM_W-1:0] rom_entry(input int unsigned k);
    logic [63:0]        y;
    logic [63:0]        y2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        e;
    logic signed [63:0] sum;
    y    = (PI_Q30 * 64'(k)) / RomDen;
    y2   = (y * y) >> 30;
    term = y;
    sum  = $signed(y);
    for (int i = 1; i <= 11; i++) begin
      term = ((term * y2) >> 30) / TAYLOR_DIV[i];
      if ((i % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(64'd1 << 30)) begin
      sum = $signed(64'd1 << 30);
    end
    s = $unsigned(sum);
    e = (s * s) >> 44;
    if (e > 64'd65535) begin
      e = 64'd65535;
    end
    rom_entry = e[ROM_W-1:0];
  endfunction

  logic [ROM_W-1:0] cos_rom [COSINE_ROM_DEPTH];

  for (genvar g = 0; g < COSINE_ROM_DEPTH; g++) begin : g_rom
    assign cos_rom[g] = rom_entry(g);
  end

  // ---------------------------------------------------------------- registers
  logic [12:0]       frame_width_q, frame_height_q;
  logic [7:0]        max_level_q;
  logic [9:0]        edge_width_q;
  logic [STEP_W-1:0] edge_phase_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= RST_FRAME_WIDTH;
      frame_height_q    <= RST_FRAME_HEIGHT;
      max_level_q       <= RST_MAX_LEVEL;
      edge_width_q      <= RST_EDGE_WIDTH;
      edge_phase_step_q <= RST_EDGE_PHASE_STEP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:     frame_width_q     <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT:    frame_height_q    <= cfg_data_i[12:0];
        CFG_MAX_LEVEL:       max_level_q       <= cfg_data_i[7:0];
        CFG_EDGE_WIDTH:      edge_width_q      <= cfg_data_i[9:0];
        CFG_EDGE_PHASE_STEP: edge_phase_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bar geometry, refreshed every cycle from the registers
  logic [BW_W-1:0]  bw_d, bw_q;
  logic [BW_W-1:0]  e_d, e_q;
  logic [BW_W-2:0]  eh_d, eh_q;
  logic [BW_W-1:0]  ehu_d;
  logic [T_W-1:0]   bwe1_d, bwe1_q;
  logic [12:0]      lower_start_d, lower_start_q;
  logic [14:0]      h4;
  logic [30:0]      h4_prod;
  logic [POS_W-1:0] base_d [NUM_BARS];
  logic [POS_W-1:0] base_q [NUM_BARS];
  logic [POS_W-1:0] start_d [NUM_BARS];
  logic [POS_W-1:0] start_q [NUM_BARS];
  logic [POS_W-1:0] stop_d [NUM_BARS];
  logic [POS_W-1:0] stop_q [NUM_BARS];

  always_comb begin
    bw_d   = frame_width_q[12:3];
    e_d    = (edge_width_q < bw_d) ? edge_width_q : bw_d;
    eh_d   = e_d[BW_W-1:1];
    ehu_d  = BW_W'((T_W'(e_d) + T_W'(1)) >> 1);
    bwe1_d = T_W'(bw_d) + T_W'(e_d) - T_W'(1);
    h4            = {frame_height_q, 2'b00};
    h4_prod       = 31'(h4) * 31'(DIV5_RECIP);
    lower_start_d = 13'(h4_prod >> DIV5_SHIFT);
    for (int c = 0; c < NUM_BARS; c++) begin
      base_d[c]  = POS_W'(bw_d) * POS_W'(c);
      start_d[c] = (c == 0) ? '0 : base_d[c] - POS_W'(eh_d);
      stop_d[c]  = POS_W'(bw_d) * POS_W'(c + 1) + POS_W'(ehu_d);
    end
  end

  always_ff @(posedge clk_i) begin
    bw_q          <= bw_d;
    e_q           <= e_d;
    eh_q          <= eh_d;
    bwe1_q        <= bwe1_d;
    lower_start_q <= lower_start_d;
    base_q        <= base_d;
    start_q       <= start_d;
    stop_q        <= stop_d;
  end

  // ---------------------------------------------------------------- flow control
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  // Hold off pixels while a register write is on the port
  assign in_ready_o  = adv[0] && !cfg_valid_i;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i && in_ready_o;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: input beat
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_x_q <= in_data_i.x_pos;
      s1_y_q <= in_data_i.y_pos;
    end
  end

  // ---------------------------------------------------------------- stage 2: bar coverage
  logic                s1_lower;
  logic [NUM_BARS-1:0] s1_cover;
  logic [POS_W-1:0]    s1_xpos;
  logic                s2_lower_q;
  logic [NUM_BARS-1:0] s2_cover_q;
  logic [POS_W-1:0]    s2_xe2_q;

  always_comb begin
    s1_xpos  = POS_W'(s1_x_q);
    s1_lower = 13'(s1_y_q) >= lower_start_q;
    for (int c = 0; c < NUM_BARS; c++) begin
      s1_cover[c] = (s1_xpos >= start_q[c]) && (s1_xpos < stop_q[c]) &&
                    (bar_mask(BAR_IDX_W'(c), s1_lower) != 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_lower_q <= s1_lower;
      s2_cover_q <= s1_cover;
      s2_xe2_q   <= s1_xpos + POS_W'(eh_q);
    end
  end

  // ---------------------------------------------------------------- stage 3: template offset
  // Neighboring bars alternate parity, so slot 0 takes the even bar and slot 1 the odd one
  logic [T_W-1:0]   s2_t [2];
  logic [2:0]       s2_mask [2];
  logic [POS_W-1:0] s2_diff [2];
  logic [T_W-1:0]   s3_t_q [2];
  logic [2:0]       s3_mask_q [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      s2_diff[j] = '0;
      s2_mask[j] = 3'd0;
      for (int i = 0; i < NUM_BARS / 2; i++) begin
        if (s2_cover_q[2*i+j]) begin
          s2_diff[j] = s2_xe2_q - base_q[2*i+j];
          s2_mask[j] = bar_mask(BAR_IDX_W'(2*i+j), s2_lower_q);
        end
      end
      s2_t[j] = s2_diff[j][T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_t_q    <= s2_t;
      s3_mask_q <= s2_mask;
    end
  end

  // ---------------------------------------------------------------- stage 4: ramp sample index
  logic [T_W-1:0] s3_fall [2];
  logic           s3_ramp [2];
  logic [N_W-1:0] s4_n_q [2];
  logic           s4_flat_q [2];
  logic [2:0]     s4_mask_q [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      s3_fall[j] = bwe1_q - s3_t_q[j];
      s3_ramp[j] = s3_t_q[j] < T_W'(e_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int j = 0; j < 2; j++) begin
        s4_n_q[j]    <= s3_ramp[j] ? s3_t_q[j][N_W-1:0] : s3_fall[j][N_W-1:0];
        s4_flat_q[j] <= !s3_ramp[j] && (s3_t_q[j] < T_W'(bw_q));
      end
      s4_mask_q <= s3_mask_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: phase product
  logic [PROD_W-1:0] s5_prod_q [2];
  logic              s5_flat_q [2];
  logic [2:0]        s5_mask_q [2];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int j = 0; j < 2; j++) begin
        s5_prod_q[j] <= (PROD_W'(s4_n_q[j]) + PROD_W'(1)) * PROD_W'(edge_phase_step_q);
      end
      s5_flat_q <= s4_flat_q;
      s5_mask_q <= s4_mask_q;
    end
  end

  // ---------------------------------------------------------------- stage 6: ROM address
  logic [KW-1:0]    s5_kfull [2];
  logic [RomAw-1:0] s6_k_q [2];
  logic             s6_flat_q [2];
  logic [2:0]       s6_mask_q [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      s5_kfull[j] = (KW'(s5_prod_q[j]) * KW'(COSINE_ROM_DEPTH)) >> 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int j = 0; j < 2; j++) begin
        // Saturate a phase past the end to the last entry
        s6_k_q[j] <= (s5_kfull[j] > KW'(COSINE_ROM_DEPTH - 1)) ?
                     RomAw'(COSINE_ROM_DEPTH - 1) : s5_kfull[j][RomAw-1:0];
      end
      s6_flat_q <= s5_flat_q;
      s6_mask_q <= s5_mask_q;
    end
  end

  // ---------------------------------------------------------------- stage 7: ROM read
  logic [ROM_W-1:0] s7_rom_q [2];
  logic             s7_flat_q [2];
  logic [2:0]       s7_mask_q [2];

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      for (int j = 0; j < 2; j++) begin
        s7_rom_q[j] <= cos_rom[s6_k_q[j]];
      end
      s7_flat_q <= s6_flat_q;
      s7_mask_q <= s6_mask_q;
    end
  end

  // ---------------------------------------------------------------- stage 8: bar level
  logic [23:0]        s7_scaled [2];
  logic [LEVEL_W-1:0] s8_lvl_q [2];
  logic [2:0]         s8_mask_q [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      s7_scaled[j] = (24'(max_level_q) * 24'(s7_rom_q[j])) >> 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      for (int j = 0; j < 2; j++) begin
        s8_lvl_q[j] <= s7_flat_q[j] ? max_level_q : s7_scaled[j][LEVEL_W-1:0];
      end
      s8_mask_q <= s7_mask_q;
    end
  end

  // ---------------------------------------------------------------- stage 9: mix and clamp
  logic [LEVEL_W:0]   s8_acc [3];
  logic [LEVEL_W-1:0] s8_chan [3];
  cbp_out_t           out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      s8_acc[ch]  = (s8_mask_q[0][ch] ? (LEVEL_W+1)'(s8_lvl_q[0]) : '0) +
                    (s8_mask_q[1][ch] ? (LEVEL_W+1)'(s8_lvl_q[1]) : '0);
      s8_chan[ch] = (s8_acc[ch] > (LEVEL_W+1)'(max_level_q)) ?
                    max_level_q : s8_acc[ch][LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      out_q.red   <= s8_chan[0];
      out_q.green <= s8_chan[1];
      out_q.blue  <= s8_chan[2];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
